// ===== rtl/cref_pkg.sv =====
// Shared types, character constants, radices and sizes for the cell reference converter.
package cref_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_t;

  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UZ   = 8'h5A;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LZ   = 8'h7A;
  localparam logic [7:0] CH_UC   = 8'h43;
  localparam logic [7:0] CH_UR   = 8'h52;
  localparam logic [7:0] CH_D0   = 8'h30;
  localparam logic [7:0] CH_D9   = 8'h39;

  localparam logic [5:0] RADIX_LET = 6'd26;
  localparam logic [5:0] RADIX_DEC = 6'd10;

  localparam int RESULT_CAP  = 28;
  localparam int STACK_DEPTH = 24;
  localparam int STACK_W     = 5;
  localparam int OCNT_W      = 5;

endpackage

// ===== rtl/cref_divider.sv =====
// Byte-serial divider by a constant radix of 10 or 26, using reciprocal multiplication.
module cref_divider #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             is_letter_radix,
  input  logic [WIDTH-1:0] dividend,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [4:0]       remainder
);
  import cref_pkg::*;

  localparam int STEPS = (WIDTH + 7) / 8;
  localparam int PW    = STEPS * 8;
  localparam int CNT_W = $clog2(STEPS + 1);

  // floor(x * RECIP >> SHIFT) equals x / radix for every partial value below radix * 256
  localparam logic [13:0] RECIP_DEC = 14'd3277;
  localparam logic [13:0] RECIP_LET = 14'd10083;

  logic [PW-1:0]    q_r;
  logic [4:0]       rem_r;
  logic             is26_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [12:0] part;
  logic [24:0] prod10;
  logic [26:0] prod26;
  logic [7:0]  qbyte;
  logic [12:0] back_prod;
  logic [12:0] part_rem;

  // partial remainder joined with the next dividend byte
  assign part      = {rem_r, q_r[PW-1 -: 8]};
  assign prod10    = 25'(part) * 25'(RECIP_DEC);
  assign prod26    = 27'(part) * 27'(RECIP_LET);
  assign qbyte     = is26_r ? prod26[25:18] : prod10[22:15];
  assign back_prod = 13'(qbyte) * 13'(is26_r ? RADIX_LET : RADIX_DEC);
  assign part_rem  = part - back_prod;

  // load the dividend, then retire one byte per cycle from the top
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= PW'(dividend);
        rem_r  <= '0;
        is26_r <= is_letter_radix;
        cnt_r  <= CNT_W'(STEPS);
      end else if (cnt_r != '0) begin
        q_r    <= {q_r[PW-9:0], qbyte};
        rem_r  <= part_rem[4:0];
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  assign done      = done_r;
  assign quotient  = q_r[WIDTH-1:0];
  assign remainder = rem_r;

endmodule

// ===== rtl/cref_queue.sv =====
// Two-entry job queue with a banked tail character store between front and back.
module cref_queue #(
  parameter int TAIL_DEPTH  = 16,
  parameter int NUMBER_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // front side
  input  logic                           tail_we,
  input  logic [$clog2(TAIL_DEPTH)-1:0]  tail_widx,
  input  logic [7:0]                     tail_wdata,
  input  logic                           push,
  input  logic                           push_a1,
  input  logic [$clog2(TAIL_DEPTH+1)-1:0] push_tcnt,
  input  logic [NUMBER_BITS-1:0]         push_num_a,
  input  logic [NUMBER_BITS-1:0]         push_num_b,
  output logic                           full,
  // back side
  output logic                           empty,
  output logic                           head_a1,
  output logic [$clog2(TAIL_DEPTH+1)-1:0] head_tcnt,
  output logic [NUMBER_BITS-1:0]         head_num_a,
  output logic [NUMBER_BITS-1:0]         head_num_b,
  input  logic [$clog2(TAIL_DEPTH)-1:0]  tail_ridx,
  output logic [7:0]                     tail_rdata,
  input  logic                           pop
);
  import cref_pkg::*;

  localparam int CW = $clog2(TAIL_DEPTH + 1);
  localparam int AW = $clog2(2 * TAIL_DEPTH);

  logic [7:0]             tail_mem [2*TAIL_DEPTH];
  logic                   a1_r   [2];
  logic [CW-1:0]          tcnt_r [2];
  logic [NUMBER_BITS-1:0] numa_r [2];
  logic [NUMBER_BITS-1:0] numb_r [2];
  logic                   wptr_r;
  logic                   rptr_r;
  logic [1:0]             cnt_r;
  logic [7:0]             rdata_r;

  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  // bank select: the second bank sits above the first
  assign waddr = wptr_r ? AW'(tail_widx) + AW'(TAIL_DEPTH) : AW'(tail_widx);
  assign raddr = rptr_r ? AW'(tail_ridx) + AW'(TAIL_DEPTH) : AW'(tail_ridx);

  // tail store write and registered read
  always_ff @(posedge clk) begin
    if (tail_we) begin
      tail_mem[waddr] <= tail_wdata;
    end
    rdata_r <= tail_mem[raddr];
  end

  // job descriptors
  always_ff @(posedge clk) begin
    if (push) begin
      a1_r[wptr_r]   <= push_a1;
      tcnt_r[wptr_r] <= push_tcnt;
      numa_r[wptr_r] <= push_num_a;
      numb_r[wptr_r] <= push_num_b;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign full       = (cnt_r == 2'd2);
  assign empty      = (cnt_r == 2'd0);
  assign head_a1    = a1_r[rptr_r];
  assign head_tcnt  = tcnt_r[rptr_r];
  assign head_num_a = numa_r[rptr_r];
  assign head_num_b = numb_r[rptr_r];
  assign tail_rdata = rdata_r;

endmodule

// ===== rtl/cref_front.sv =====
// Front end: accepts characters, classifies the form and builds the numbers.
module cref_front #(
  parameter int TAIL_DEPTH  = 16,
  parameter int NUMBER_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  cref_pkg::in_t                   in_data,
  output logic                            tail_we,
  output logic [$clog2(TAIL_DEPTH)-1:0]   tail_widx,
  output logic [7:0]                      tail_wdata,
  output logic                            push,
  output logic                            push_a1,
  output logic [$clog2(TAIL_DEPTH+1)-1:0] push_tcnt,
  output logic [NUMBER_BITS-1:0]          push_num_a,
  output logic [NUMBER_BITS-1:0]          push_num_b
);
  import cref_pkg::*;

  localparam int IW = $clog2(TAIL_DEPTH);
  localparam int CW = $clog2(TAIL_DEPTH + 1);
  localparam int NW = NUMBER_BITS;

  logic [4:0]    pos_r,   pos_nxt;
  logic          lf_r,    lf_nxt;
  logic [NW-1:0] lv_r,    lv_nxt;
  logic [CW-1:0] tcnt_r,  tcnt_nxt;
  logic          sil_r,   sil_nxt;
  logic          cs_r,    cs_nxt;
  logic [NW-1:0] row_r,   row_nxt;
  logic [NW-1:0] col_r,   col_nxt;
  logic [1:0]    phase_r, phase_nxt;

  logic [7:0]    c;
  logic          is_let;
  logic          is_dig;
  logic [NW-1:0] c_ext;
  logic [NW-1:0] dig_ext;

  assign c       = in_data.in_char;
  assign is_let  = (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
  assign is_dig  = (c >= CH_D0 && c <= CH_D9);
  assign c_ext   = NW'(c);
  assign dig_ext = NW'(c - CH_D0);

  // next state for one accepted character
  always_comb begin
    pos_nxt    = pos_r;
    lf_nxt     = lf_r;
    lv_nxt     = lv_r;
    tcnt_nxt   = tcnt_r;
    sil_nxt    = sil_r;
    cs_nxt     = cs_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    phase_nxt  = phase_r;
    tail_we    = 1'b0;
    tail_widx  = tcnt_r[IW-1:0];
    tail_wdata = c;

    // leading letters build the column, the rest goes to the tail until it is full
    if (!lf_r && is_let) begin
      lv_nxt = (lv_r << 4) + (lv_r << 3) + (lv_r << 1) + c_ext - NW'(CH_UA) + NW'(1);
    end else begin
      lf_nxt = 1'b1;
      if (tcnt_r < CW'(TAIL_DEPTH)) begin
        tail_we  = accept;
        tcnt_nxt = tcnt_r + 1'b1;
      end
    end

    if (pos_r == 5'd1) sil_nxt = is_let;
    if (pos_r != 5'd0 && c == CH_UC) cs_nxt = 1'b1;

    // row and column fields of the numeric form
    if (pos_r == 5'd0) begin
      phase_nxt = 2'd1;
    end else if (phase_r == 2'd1) begin
      if (is_dig) row_nxt = (row_r << 3) + (row_r << 1) + dig_ext;
      else        phase_nxt = 2'd2;
    end else if (phase_r == 2'd2) begin
      if (is_dig) col_nxt = (col_r << 3) + (col_r << 1) + dig_ext;
      else        phase_nxt = 2'd3;
    end

    if (pos_r != 5'd31) pos_nxt = pos_r + 1'b1;
  end

  assign push       = accept && in_data.in_last;
  assign push_a1    = sil_nxt || !cs_nxt;
  assign push_tcnt  = tcnt_nxt;
  assign push_num_a = push_a1 ? lv_nxt : row_nxt;
  assign push_num_b = col_nxt;

  // hold parse state; clear it after the last character
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      pos_r   <= '0;
      lf_r    <= 1'b0;
      lv_r    <= '0;
      tcnt_r  <= '0;
      sil_r   <= 1'b0;
      cs_r    <= 1'b0;
      row_r   <= '0;
      col_r   <= '0;
      phase_r <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      lf_r    <= lf_nxt;
      lv_r    <= lv_nxt;
      tcnt_r  <= tcnt_nxt;
      sil_r   <= sil_nxt;
      cs_r    <= cs_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== rtl/cref_back.sv =====
// Back end: sequences one job into output characters through the divider and a stack.
module cref_back #(
  parameter int TAIL_DEPTH  = 16,
  parameter int NUMBER_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  logic                            head_a1,
  input  logic [$clog2(TAIL_DEPTH+1)-1:0] head_tcnt,
  input  logic [NUMBER_BITS-1:0]          head_num_a,
  input  logic [NUMBER_BITS-1:0]          head_num_b,
  output logic [$clog2(TAIL_DEPTH)-1:0]   tail_ridx,
  input  logic [7:0]                      tail_rdata,
  output logic                            pop,
  output logic                            out_valid,
  output cref_pkg::out_t                  out_data
);
  import cref_pkg::*;

  localparam int IW = $clog2(TAIL_DEPTH);
  localparam int CW = $clog2(TAIL_DEPTH + 1);
  localparam int NW = NUMBER_BITS;

  typedef enum logic [3:0] {
    B_IDLE, B_R, B_TRD, B_TEM, B_C, B_LCHK, B_LWT, B_DST, B_DWT, B_POP, B_DONE
  } bstate_t;

  bstate_t              state_r;
  logic [NW-1:0]        val_r;
  logic [CW-1:0]        tidx_r;
  logic [STACK_W-1:0]   sp_r;
  logic                 dec_r;
  logic [7:0]           stk_r [STACK_DEPTH];
  logic [OCNT_W-1:0]    ocnt_r;
  logic                 ov_r;
  out_t                 od_r;

  logic                 div_start;
  logic                 div_is26;
  logic [NW-1:0]        div_in;
  logic                 div_done;
  logic [NW-1:0]        div_q;
  logic [4:0]           div_rem;

  logic                 emit;
  logic [7:0]           emit_ch;
  logic                 emit_fin;
  logic [STACK_W-1:0]   sp_top;

  cref_divider #(.WIDTH(NW)) u_div (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (div_start),
    .is_letter_radix (div_is26),
    .dividend        (div_in),
    .done            (div_done),
    .quotient        (div_q),
    .remainder       (div_rem)
  );

  assign sp_top    = sp_r - 1'b1;
  assign tail_ridx = tidx_r[IW-1:0];
  assign pop       = (state_r == B_DONE);

  // drive divider and emission from the current state
  always_comb begin
    div_start = 1'b0;
    div_is26  = 1'b0;
    div_in    = val_r;
    emit      = 1'b0;
    emit_ch   = CH_UR;
    emit_fin  = 1'b0;
    unique case (state_r)
      B_R:   emit = 1'b1;
      B_TEM: begin
        emit    = 1'b1;
        emit_ch = tail_rdata;
      end
      B_C: begin
        emit    = 1'b1;
        emit_ch = CH_UC;
      end
      B_LCHK: begin
        div_start = (val_r != '0);
        div_is26  = 1'b1;
        div_in    = val_r - 1'b1;
      end
      B_DST: div_start = 1'b1;
      B_POP: begin
        emit     = (sp_r != '0);
        emit_ch  = stk_r[sp_top];
        emit_fin = dec_r && (sp_r == STACK_W'(1));
      end
      default: ;
    endcase
  end

  // hold sequencer state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
      ocnt_r  <= '0;
      sp_r    <= '0;
      tidx_r  <= '0;
      dec_r   <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      // drop anything past the result cap; the last kept one is marked final
      if (emit && ocnt_r < OCNT_W'(RESULT_CAP)) begin
        ov_r        <= 1'b1;
        od_r.out_char <= emit_ch;
        od_r.out_last <= emit_fin || (ocnt_r == OCNT_W'(RESULT_CAP - 1));
        ocnt_r      <= ocnt_r + 1'b1;
      end
      unique case (state_r)
        B_IDLE: begin
          ocnt_r <= '0;
          sp_r   <= '0;
          tidx_r <= '0;
          if (!q_empty) begin
            if (head_a1) begin
              state_r <= B_R;
            end else begin
              val_r   <= head_num_b;
              state_r <= B_LCHK;
            end
          end
        end
        B_R:   state_r <= B_TRD;
        B_TRD: state_r <= (tidx_r == head_tcnt) ? B_C : B_TEM;
        B_TEM: begin
          tidx_r  <= tidx_r + 1'b1;
          state_r <= B_TRD;
        end
        B_C: begin
          val_r   <= head_num_a;
          state_r <= B_DST;
        end
        B_LCHK: begin
          if (val_r == '0) begin
            dec_r   <= 1'b0;
            state_r <= B_POP;
          end else begin
            state_r <= B_LWT;
          end
        end
        B_LWT: begin
          if (div_done) begin
            stk_r[sp_r] <= CH_UA + {3'b000, div_rem};
            sp_r        <= sp_r + 1'b1;
            val_r       <= div_q;
            state_r     <= B_LCHK;
          end
        end
        B_DST: state_r <= B_DWT;
        B_DWT: begin
          if (div_done) begin
            stk_r[sp_r] <= CH_D0 + {3'b000, div_rem};
            sp_r        <= sp_r + 1'b1;
            val_r       <= div_q;
            if (div_q == '0) begin
              dec_r   <= 1'b1;
              state_r <= B_POP;
            end else begin
              state_r <= B_DST;
            end
          end
        end
        B_POP: begin
          if (sp_r != '0) begin
            sp_r <= sp_top;
          end else if (dec_r) begin
            state_r <= B_DONE;
          end else begin
            val_r   <= head_num_a;
            state_r <= B_DST;
          end
        end
        B_DONE: state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ===== rtl/cell_reference_converter.sv =====
// Cell reference converter top level: front end, job queue and back end.
// Characters are taken one per cycle; busy rises only while two references wait in the queue.
// After the last character each tail character passes through a read state and an emit state, and
// each letter or digit takes one divider run, one byte per divider step.
// Results come one per cycle at most, each on out_valid for one cycle; up to 28 per reference.
// Synchronous active-low reset clears control state; the tail store is not cleared.
module cell_reference_converter #(
  parameter int TAIL_DEPTH  = 16,
  parameter int NUMBER_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  cref_pkg::in_t  in_data,
  output logic           out_valid,
  output cref_pkg::out_t out_data
);
  import cref_pkg::*;

  localparam int IW = $clog2(TAIL_DEPTH);
  localparam int CW = $clog2(TAIL_DEPTH + 1);

  logic                   accept;
  logic                   tail_we;
  logic [IW-1:0]          tail_widx;
  logic [7:0]             tail_wdata;
  logic                   push;
  logic                   push_a1;
  logic [CW-1:0]          push_tcnt;
  logic [NUMBER_BITS-1:0] push_num_a;
  logic [NUMBER_BITS-1:0] push_num_b;
  logic                   q_full;
  logic                   q_empty;
  logic                   head_a1;
  logic [CW-1:0]          head_tcnt;
  logic [NUMBER_BITS-1:0] head_num_a;
  logic [NUMBER_BITS-1:0] head_num_b;
  logic [IW-1:0]          tail_ridx;
  logic [7:0]             tail_rdata;
  logic                   pop;

  assign busy   = q_full;
  assign accept = start && !busy;

  cref_front #(.TAIL_DEPTH(TAIL_DEPTH), .NUMBER_BITS(NUMBER_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_data    (in_data),
    .tail_we    (tail_we),
    .tail_widx  (tail_widx),
    .tail_wdata (tail_wdata),
    .push       (push),
    .push_a1    (push_a1),
    .push_tcnt  (push_tcnt),
    .push_num_a (push_num_a),
    .push_num_b (push_num_b)
  );

  cref_queue #(.TAIL_DEPTH(TAIL_DEPTH), .NUMBER_BITS(NUMBER_BITS)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .tail_we    (tail_we),
    .tail_widx  (tail_widx),
    .tail_wdata (tail_wdata),
    .push       (push),
    .push_a1    (push_a1),
    .push_tcnt  (push_tcnt),
    .push_num_a (push_num_a),
    .push_num_b (push_num_b),
    .full       (q_full),
    .empty      (q_empty),
    .head_a1    (head_a1),
    .head_tcnt  (head_tcnt),
    .head_num_a (head_num_a),
    .head_num_b (head_num_b),
    .tail_ridx  (tail_ridx),
    .tail_rdata (tail_rdata),
    .pop        (pop)
  );

  cref_back #(.TAIL_DEPTH(TAIL_DEPTH), .NUMBER_BITS(NUMBER_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .head_a1    (head_a1),
    .head_tcnt  (head_tcnt),
    .head_num_a (head_num_a),
    .head_num_b (head_num_b),
    .tail_ridx  (tail_ridx),
    .tail_rdata (tail_rdata),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  // queue can never be both full and empty
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue full and empty at once");

  // a final transaction leaves a job waiting in the queue
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.in_last) |=> !q_empty)
    else $error("finished reference not queued");

  // the final result of a reference is followed by a gap
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_last) |=> !out_valid)
    else $error("result right after final result");

  // a job is never popped from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

// ===== tb/sv/cell_reference_converter_tb.sv =====
// Self-checking testbench for the cell reference converter: A1 and R1C1 conversion.
module cell_reference_converter_tb;
  import cref_pkg::*;

  localparam int TAIL_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 360;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  cell_reference_converter #(.TAIL_DEPTH(TAIL_DEPTH), .NUMBER_BITS(32)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // Converter state held by the predictor
  logic [4:0]  pos_q = '0;
  logic        letters_done_q = 1'b0;
  logic [31:0] letter_col_q = '0;
  logic [7:0]  tail_q [TAIL_DEPTH];
  int          tail_cnt_q = 0;
  logic        second_letter_q = 1'b0;
  logic        c_later_q = 1'b0;
  logic [31:0] row_q = '0;
  logic [31:0] col_q = '0;
  logic [1:0]  phase_q = '0;

  in_t  pending_chars [$];
  out_t expected_chars[$];
  int   error_count = 0;
  int   cycle_count = 0;
  int   ref_count = 0;
  int   result_count = 0;
  int   a1_count = 0;
  int   r1c1_count = 0;
  int   queued_count = 0;
  int   quiet_end;
  logic took;
  logic hold_for_drain;
  logic quiet_mode;
  logic drain_done;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
  endfunction

  task automatic clear_converter();
    pos_q = '0; letters_done_q = 1'b0; letter_col_q = '0; tail_cnt_q = 0;
    second_letter_q = 1'b0; c_later_q = 1'b0; row_q = '0; col_q = '0; phase_q = '0;
  endtask

  task automatic push_char(logic [7:0] c);
    out_t r;
    r.out_char = c;
    r.out_last = 1'b0;
    if (result_count < RESULT_CAP) expected_chars.push_back(r);
    result_count++;
  endtask

  task automatic push_decimal(logic [31:0] v);
    logic [7:0] digs [$];
    do begin
      digs.push_back(CH_D0 + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    for (int i = digs.size() - 1; i >= 0; i--) push_char(digs[i]);
  endtask

  // Advance the converter model by one accepted character
  task automatic convert_char(in_t t);
    logic [7:0] c;
    logic       dig;
    logic [7:0] lets [$];
    logic [31:0] cv;
    int first;
    c = t.in_char;
    dig = (c >= CH_D0 && c <= CH_D9);
    if (!letters_done_q && is_alpha(c)) begin
      letter_col_q = letter_col_q * 26 + 32'(c) - 32'(CH_UA) + 1;
    end else begin
      letters_done_q = 1'b1;
      if (tail_cnt_q < TAIL_DEPTH) begin
        tail_q[tail_cnt_q] = c;
        tail_cnt_q++;
      end
    end
    if (pos_q == 1) second_letter_q = is_alpha(c);
    if (pos_q >= 1 && c == CH_UC) c_later_q = 1'b1;
    if (pos_q == 0) begin
      phase_q = 2'd1;
    end else if (phase_q == 2'd1) begin
      if (dig) row_q = row_q * 10 + 32'(c - CH_D0);
      else phase_q = 2'd2;
    end else if (phase_q == 2'd2) begin
      if (dig) col_q = col_q * 10 + 32'(c - CH_D0);
      else phase_q = 2'd3;
    end
    if (pos_q < 31) pos_q++;
    if (!t.in_last) return;
    // Emit the converted reference
    first = expected_chars.size();
    result_count = 0;
    ref_count++;
    if (second_letter_q || !c_later_q) begin
      a1_count++;
      push_char(CH_UR);
      for (int i = 0; i < tail_cnt_q; i++) push_char(tail_q[i]);
      push_char(CH_UC);
      push_decimal(letter_col_q);
    end else begin
      r1c1_count++;
      cv = col_q;
      while (cv > 0) begin
        cv = cv - 1;
        lets.push_back(CH_UA + 8'(cv % 26));
        cv = cv / 26;
      end
      for (int i = lets.size() - 1; i >= 0; i--) push_char(lets[i]);
      push_decimal(row_q);
    end
    if (expected_chars.size() > first)
      expected_chars[expected_chars.size() - 1].out_last = 1'b1;
    clear_converter();
  endtask

  // Queue one character
  task automatic queue_char(logic [7:0] c, logic last);
    in_t t;
    t.in_char = c;
    t.in_last = last;
    pending_chars.push_back(t);
    queued_count++;
  endtask

  // Queue one reference string
  task automatic queue_ref(string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i], i == s.len() - 1);
  endtask

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'(CH_D0 + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_letters(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'(CH_UA + $urandom_range(0, 25)))};
    return s;
  endfunction

  // Drive transactions at the falling edge; hold one until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
    end else begin
      if (took) void'(pending_chars.pop_front());
      if (start && !took) begin
        start <= 1'b1;
      end else if (pending_chars.size() > 0 && !hold_for_drain &&
                   (quiet_mode || $urandom_range(0, 99) >= 37)) begin
        start   <= 1'b1;
        in_data <= pending_chars[0];
      end else begin
        start   <= 1'b0;
        in_data <= in_t'(9'($urandom));
      end
    end
  end

  // Predict on accepted transactions and check results
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    took = rst_n && start && !busy;
    if (took) convert_char(in_data);
    if (rst_n && out_valid) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h/%b",
                 $time, out_data.out_char, out_data.out_last);
        error_count++;
      end else begin
        if (out_data.out_char !== expected_chars[0].out_char ||
            out_data.out_last !== expected_chars[0].out_last) begin
          $display("%0t: mismatch expected %h/%b actual %h/%b", $time,
                   expected_chars[0].out_char, expected_chars[0].out_last,
                   out_data.out_char, out_data.out_last);
          error_count++;
        end
        void'(expected_chars.pop_front());
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cell_reference_converter_tb: errors");
      $finish;
    end
  end

  initial begin
    string s;
    int    pick;
    int    n;
    rst_n = 1'b0;
    hold_for_drain = 1'b0; quiet_mode = 1'b0; drain_done = 1'b0; quiet_end = 0;
    // Directed references: corners of both forms
    queue_ref("A1");
    queue_ref("Z");
    queue_ref("AZ99");
    queue_ref("R1C1");
    queue_ref("R0C0");
    queue_ref("R23C55");
    queue_ref("R4294967295C4294967295");
    queue_ref("RC");
    queue_ref("zz1");
    queue_ref("BC");
    queue_ref("A12345678901234567890");
    queue_ref({"R5C7X", string'(8'hFF), "9"});
    queue_char(8'h00, 1'b0);
    queue_char(8'h80, 1'b0);
    queue_char(CH_UC, 1'b0);
    queue_char(8'h33, 1'b1);
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    // Random references, mostly well formed
    while (queued_count < ITEM_TARGET || pending_chars.size() > 0) begin
      if (queued_count < ITEM_TARGET && pending_chars.size() < 30) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          queue_ref({rand_letters($urandom_range(1, 4)), rand_digits($urandom_range(1, 7))});
        end else if (pick < 8) begin
          s = {"R", rand_digits($urandom_range(1, 10)), "C",
               rand_digits($urandom_range(1, 10))};
          queue_ref(s);
        end else begin
          n = $urandom_range(1, 22);
          for (int i = 0; i < n; i++) queue_char(8'($urandom_range(0, 255)), i == n - 1);
        end
      end
      // Let results drain once mid-run, then run a stretch with no idling
      if (!drain_done && ref_count >= 20) begin
        hold_for_drain = 1'b1;
        while (expected_chars.size() != 0) @(posedge clk);
        hold_for_drain = 1'b0;
        drain_done = 1'b1;
        quiet_mode = 1'b1;
        quiet_end  = ref_count + 8;
      end
      if (quiet_mode && ref_count >= quiet_end) quiet_mode = 1'b0;
      @(posedge clk);
    end
    while (start || expected_chars.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d characters in %0d references: %0d A1 and %0d R1C1 inputs,",
             queued_count, ref_count, a1_count, r1c1_count);
    $display("including one full drain and a stretch with no idle cycles.");
    if (error_count == 0) begin
      $display("cell_reference_converter_tb: clean");
    end else begin
      $display("cell_reference_converter_tb: errors");
    end
    $finish;
  end

endmodule
